// ----- src/edf_sched_pkg.sv -----
`default_nettype none

package edf_sched_pkg;

  // List depth and derived widths
  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Request codes
  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_DONE    = 2'd2,
    REQ_SPARE   = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_TICK     = 3'd0,
    ST_RELEASED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_DONE     = 3'd3,
    ST_MISMATCH = 3'd4,
    ST_IGNORED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_tick;
    logic [7:0]  task_id;
    logic [31:0] release_deadline;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] done_task_id;
    logic       overdue;
    logic [7:0] overdue_task_id;
    logic       preempted;
    logic [7:0] preempted_task_id;
    logic       running_valid;
    logic [7:0] running_task_id;
    logic [4:0] active_count;
  } out_word_t;

  // One slot of the active list
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] deadline;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Low five bits of the list count
  function automatic logic [4:0] count_field(input logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[4:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/edf_sched_if.sv -----
`default_nettype none

interface edf_sched_in_if import edf_sched_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface edf_sched_out_if import edf_sched_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/edf_task_scheduler.sv -----
// Earliest-deadline-first scheduler.
// in_ch carries one event word per handshake (valid/ready): a plain tick, a
// task release with its absolute deadline, or a completion of the running
// task. Every event yields exactly one result word on out_ch with the event
// status, any overdue removal or preemption, the running task and the list
// size.
// The active list lives in a single-port-write, registered-read RAM and is
// kept sorted by deadline. One 32-bit magnitude comparator is reused by a
// small sequencer for the insert scan, the overdue check and the head check.
// A plain event passes the decode step, the overdue check, the head read
// and compare (no compare with an empty list) and the final load. An
// insert scan reads entries from the tail and shifts each one with a later
// deadline up a slot; a removal scan reads every list entry, and a
// completion skips the overdue check. A release may be followed by an
// overdue removal. One event is in work at a time; in_ready is high only
// while the sequencer is idle, which it re-enters as the result word is
// loaded. The result word sits in an output register: the next event is
// accepted while it waits, and a stalled out_ch holds the following result
// back in its final step until the register frees.
// Synchronous reset empties the list and leaves no task running.

`default_nettype none

module edf_task_scheduler import edf_sched_pkg::*; (
  input wire logic            clk,
  input wire logic            rst_n,
  edf_sched_in_if.sink        in_ch,
  edf_sched_out_if.source     out_ch
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVT,
    S_INS_RD,
    S_INS_CMP,
    S_RM_RD,
    S_RM_CMP,
    S_OVD,
    S_HEAD_RD,
    S_HEAD_CMP,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  in_word_t         evt_r, evt_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] ptr_dec;
  logic             found_r, found_nxt;
  logic [7:0]       rm_id_r, rm_id_nxt;
  logic             run_valid_r, run_valid_nxt;
  logic [7:0]       run_id_r, run_id_nxt;
  logic [31:0]      run_dl_r, run_dl_nxt;
  status_t          status_r, status_nxt;
  logic [7:0]       done_id_r, done_id_nxt;
  logic             ovd_r, ovd_nxt;
  logic [7:0]       ovd_id_r, ovd_id_nxt;
  logic             pre_r, pre_nxt;
  logic [7:0]       pre_id_r, pre_id_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_raddr;
  entry_t             ram_wentry;
  entry_t             ram_rentry;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [31:0] cmp_a, cmp_b;
  logic        cmp_gt;

  edf_sched_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_rentry = entry_t'(ram_rdata);
  assign ptr_dec    = ptr_r - CNT_W'(1);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Shared comparator: operands picked by the sequencer step
  always_comb begin
    unique case (state_r)
      S_INS_CMP: begin
        cmp_a = ram_rentry.deadline;
        cmp_b = evt_r.release_deadline;
      end
      S_HEAD_CMP: begin
        cmp_a = run_dl_r;
        cmp_b = ram_rentry.deadline;
      end
      default: begin
        cmp_a = evt_r.now_tick;
        cmp_b = run_dl_r;
      end
    endcase
  end

  assign cmp_gt = (cmp_a > cmp_b);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    evt_nxt       = evt_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    found_nxt     = found_r;
    rm_id_nxt     = rm_id_r;
    run_valid_nxt = run_valid_r;
    run_id_nxt    = run_id_r;
    run_dl_nxt    = run_dl_r;
    status_nxt    = status_r;
    done_id_nxt   = done_id_r;
    ovd_nxt       = ovd_r;
    ovd_id_nxt    = ovd_id_r;
    pre_nxt       = pre_r;
    pre_id_nxt    = pre_id_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r[IDX_W-1:0];
    ram_wentry    = ram_rentry;
    ram_raddr     = ptr_r[IDX_W-1:0];

    // Drop the result word once taken
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          evt_nxt     = in_ch.data;
          status_nxt  = ST_TICK;
          done_id_nxt = '0;
          ovd_nxt     = 1'b0;
          ovd_id_nxt  = '0;
          pre_nxt     = 1'b0;
          pre_id_nxt  = '0;
          state_nxt   = S_EVT;
        end
      end

      S_EVT: begin
        priority if (evt_r.req_type == REQ_RELEASE) begin
          if (count_r == CNT_W'(MAX_TASKS)) begin
            status_nxt = ST_DROPPED;
            state_nxt  = S_OVD;
          end else begin
            status_nxt = ST_RELEASED;
            ptr_nxt    = count_r;
            state_nxt  = S_INS_RD;
          end
        end else if (evt_r.req_type == REQ_DONE) begin
          priority if (!run_valid_r) begin
            status_nxt = ST_IGNORED;
            state_nxt  = S_OVD;
          end else if (evt_r.task_id != run_id_r) begin
            status_nxt = ST_MISMATCH;
            state_nxt  = S_OVD;
          end else begin
            status_nxt    = ST_DONE;
            done_id_nxt   = evt_r.task_id;
            run_valid_nxt = 1'b0;
            rm_id_nxt     = evt_r.task_id;
            ptr_nxt       = '0;
            found_nxt     = 1'b0;
            state_nxt     = S_RM_RD;
          end
        end else begin
          state_nxt = S_OVD;
        end
      end

      // Insert: walk down from the tail, shifting later deadlines up a slot
      S_INS_RD: begin
        if (ptr_r == '0) begin
          ram_we      = 1'b1;
          ram_wentry  = '{id: evt_r.task_id, deadline: evt_r.release_deadline};
          count_nxt   = count_r + CNT_W'(1);
          state_nxt   = S_OVD;
        end else begin
          ram_raddr = ptr_dec[IDX_W-1:0];
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        ram_we = 1'b1;
        if (cmp_gt) begin
          ram_wentry = ram_rentry;
          ptr_nxt    = ptr_dec;
          state_nxt  = S_INS_RD;
        end else begin
          ram_wentry = '{id: evt_r.task_id, deadline: evt_r.release_deadline};
          count_nxt  = count_r + CNT_W'(1);
          state_nxt  = S_OVD;
        end
      end

      // Removal: find the first matching id, then pull later entries down
      S_RM_RD: begin
        if (ptr_r == count_r) begin
          if (found_r) begin
            count_nxt = count_r - CNT_W'(1);
          end
          state_nxt = S_HEAD_RD;
        end else begin
          state_nxt = S_RM_CMP;
        end
      end

      S_RM_CMP: begin
        if (found_r) begin
          ram_we     = 1'b1;
          ram_waddr  = ptr_dec[IDX_W-1:0];
          ram_wentry = ram_rentry;
        end else if (ram_rentry.id == rm_id_r) begin
          found_nxt = 1'b1;
        end
        ptr_nxt   = ptr_r + CNT_W'(1);
        state_nxt = S_RM_RD;
      end

      // Remove the running task when its deadline has passed
      S_OVD: begin
        if (run_valid_r && cmp_gt) begin
          ovd_nxt       = 1'b1;
          ovd_id_nxt    = run_id_r;
          run_valid_nxt = 1'b0;
          rm_id_nxt     = run_id_r;
          ptr_nxt       = '0;
          found_nxt     = 1'b0;
          state_nxt     = S_RM_RD;
        end else begin
          state_nxt = S_HEAD_RD;
        end
      end

      S_HEAD_RD: begin
        ram_raddr = '0;
        state_nxt = (count_r == '0) ? S_FIN : S_HEAD_CMP;
      end

      // Preempt on an earlier head deadline, or start the head when idle
      S_HEAD_CMP: begin
        if (run_valid_r && cmp_gt) begin
          pre_nxt    = 1'b1;
          pre_id_nxt = run_id_r;
          run_id_nxt = ram_rentry.id;
          run_dl_nxt = ram_rentry.deadline;
        end else if (!run_valid_r) begin
          run_valid_nxt = 1'b1;
          run_id_nxt    = ram_rentry.id;
          run_dl_nxt    = ram_rentry.deadline;
        end
        state_nxt = S_FIN;
      end

      // Load the result word once the output register is free
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.status            = status_r;
          out_data_nxt.done_task_id      = done_id_r;
          out_data_nxt.overdue           = ovd_r;
          out_data_nxt.overdue_task_id   = ovd_id_r;
          out_data_nxt.preempted         = pre_r;
          out_data_nxt.preempted_task_id = pre_id_r;
          out_data_nxt.running_valid     = run_valid_r;
          out_data_nxt.running_task_id   = run_valid_r ? run_id_r : 8'd0;
          out_data_nxt.active_count      = count_field(count_r);
          state_nxt                      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      run_valid_r <= 1'b0;
      run_id_r    <= '0;
      run_dl_r    <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      run_valid_r <= run_valid_nxt;
      run_id_r    <= run_id_nxt;
      run_dl_r    <= run_dl_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
    evt_r      <= evt_nxt;
    ptr_r      <= ptr_nxt;
    rm_id_r    <= rm_id_nxt;
    status_r   <= status_nxt;
    done_id_r  <= done_id_nxt;
    ovd_r      <= ovd_nxt;
    ovd_id_r   <= ovd_id_nxt;
    pre_r      <= pre_nxt;
    pre_id_r   <= pre_id_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ----- src/edf_sched_ram.sv -----
`default_nettype none

module edf_sched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/edf_sched_chk.sv -----
`default_nettype none

module edf_sched_chk import edf_sched_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  // A pending result word stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // One event in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("event accepted while busy");

  // No running id reported without a running task
  a_run_id_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.running_valid |-> out_data.running_task_id == 8'd0)
    else $error("running id set while idle");

  // Side ids are zero unless their flag is set
  a_side_ids: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.overdue || out_data.overdue_task_id == 8'd0) &&
                  (out_data.preempted || out_data.preempted_task_id == 8'd0) &&
                  (out_data.status == ST_DONE || out_data.done_task_id == 8'd0))
    else $error("stray task id in result word");

  // List size never exceeds its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.active_count) <= 32'(MAX_TASKS % 32) ||
                  MAX_TASKS >= 32)
    else $error("active count beyond list depth");

endmodule

bind edf_task_scheduler edf_sched_chk u_edf_sched_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
